>>> sv/pit_pkg.sv
// pit_pkg: shared types and constants for the pending interest table unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package pit_pkg;

    localparam int KEY_W    = 64;
    localparam int TICK_W   = 48;
    localparam int LIFE_W   = 32;
    localparam int FACE_W   = 6;
    localparam int FSET_W   = 64;
    localparam int VERD_W   = 3;

    localparam logic [1:0] OP_INTEREST = 2'd0;
    localparam logic [1:0] OP_DATA     = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;
    localparam logic [1:0] OP_LOOKUP   = 2'd3;

    localparam logic [VERD_W-1:0] V_FORWARD    = 3'd0;
    localparam logic [VERD_W-1:0] V_AGGREGATE  = 3'd1;
    localparam logic [VERD_W-1:0] V_RETRANSMIT = 3'd2;
    localparam logic [VERD_W-1:0] V_NONE       = 3'd3;
    localparam logic [VERD_W-1:0] V_FULL       = 3'd4;

    localparam logic CFG_LIFETIME = 1'b0;
    localparam logic CFG_POLICY   = 1'b1;

    localparam logic [63:0] HASH_MUL = 64'hFF51AFD7ED558CCD;
    localparam logic [31:0] LIFE_RESET = 32'd4000;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic hash_step; // advance hash pipeline
        logic read;      // issue set read
        logic resolve;   // compare and write back
    } pit_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hash_done;
        logic clear_done;
    } pit_sts_t;

endpackage
`default_nettype wire

>>> sv/pit_ctrl.sv
// pit_ctrl: sequencer for one item: hash, set read, resolve, result hold.
// Depends on pit_pkg.
`default_nettype none
module pit_ctrl
    import pit_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    input  wire pit_sts_t sts,
    output pit_cmd_t      cmd
);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_READ, S_RESOLVE} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // a new item may enter while the last result waits in the output register,
    // but resolve stalls until that register is free
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_done)
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (!out_valid_next)
                begin
                    cmd.resolve    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/pit_datapath.sv
// pit_datapath: key hash, table memories, way compare and write back.
// Depends on pit_pkg; sequenced by pit_ctrl.
`default_nettype none
module pit_datapath
    import pit_pkg::*;
#(
    parameter int SETS  = 1024,
    parameter int WAYS  = 4,
    parameter int FACES = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pit_cmd_t          cmd,
    output pit_sts_t               sts,
    input  wire logic [1:0]        operation,
    input  wire logic [KEY_W-1:0]  name_key,
    input  wire logic [FACE_W-1:0] ingress_face,
    input  wire logic [LIFE_W-1:0] lifetime_ticks,
    input  wire logic [TICK_W-1:0] now_ticks,
    input  wire logic [LIFE_W-1:0] default_lifetime,
    input  wire logic              policy_mode,
    output logic [VERD_W-1:0]      verdict,
    output logic                   found_live,
    output logic                   timed_out,
    output logic [FSET_W-1:0]      face_set,
    output logic [TICK_W-1:0]      expiry_out
);

    localparam int SET_W = $clog2(SETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FB_W  = $clog2(FACES);
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // ---------------- captured item ----------------
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [FSET_W-1:0] fbit_reg;
    logic [TICK_W-1:0] now_reg;
    logic [TICK_W:0]   exp_sum_reg;

    logic [LIFE_W-1:0] life_eff;
    logic [FB_W-1:0]   face_mod;
    logic [FACE_W:0]   face_wide;

    // one spare bit so that FACES itself fits in the divisor
    assign life_eff  = (lifetime_ticks != '0) ? lifetime_ticks : default_lifetime;
    assign face_wide = {1'b0, ingress_face} % (FACE_W+1)'(FACES);
    assign face_mod  = face_wide[FB_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            key_reg     <= name_key;
            fbit_reg    <= FSET_W'(1) << face_mod;
            now_reg     <= now_ticks;
            exp_sum_reg <= {1'b0, now_ticks} + {{(TICK_W+1-LIFE_W){1'b0}}, life_eff};
        end
    end

    logic [TICK_W-1:0] new_exp;
    assign new_exp = exp_sum_reg[TICK_W] ? TICK_MAX : exp_sum_reg[TICK_W-1:0];

    // ---------------- hash: 64x64 multiply in four 32x32 partial products -------
    // x = k ^ (k>>33); p = x*M mod 2^64; h = p ^ (p>>33)
    logic [1:0]  hstep_reg;
    logic [63:0] hx_reg, hacc_reg;
    logic [31:0] pa, pb;
    logic [63:0] pprod;

    always_comb
    begin
        unique case (hstep_reg)
            2'd0:    begin pa = hx_reg[31:0];  pb = HASH_MUL[31:0];  end
            2'd1:    begin pa = hx_reg[31:0];  pb = HASH_MUL[63:32]; end
            2'd2:    begin pa = hx_reg[63:32]; pb = HASH_MUL[31:0];  end
            default: begin pa = hx_reg[63:32]; pb = HASH_MUL[63:32]; end
        endcase
    end
    assign pprod = 64'(pa) * 64'(pb);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hx_reg    <= name_key ^ (name_key >> 33);
            hacc_reg  <= '0;
            hstep_reg <= 2'd0;
        end
        else if (cmd.hash_step)
        begin
            hstep_reg <= hstep_reg + 2'd1;
            unique case (hstep_reg)
                2'd0:    hacc_reg <= hacc_reg + pprod;
                2'd1,
                2'd2:    hacc_reg <= hacc_reg + {pprod[31:0], 32'd0};
                default: hacc_reg <= hacc_reg;  // high x high falls above bit 63
            endcase
        end
    end

    logic [63:0] hmix;
    logic [63:0] hmod;
    logic [SET_W-1:0] set_idx;
    assign hmix    = hacc_reg ^ (hacc_reg >> 33);
    assign hmod    = hmix % 64'(SETS);
    assign set_idx = hmod[SET_W-1:0];
    assign sts.hash_done = (hstep_reg == 2'd3);

    // ---------------- table: one row per set, all ways side by side --------------
    localparam int ROW_W = WAYS * (KEY_W + TICK_W + FSET_W);

    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] row_rd_reg;
    logic [WAYS-1:0]  vld_rd_reg;
    logic [SET_W-1:0] set_reg;

    // valid bits live in a separate row memory cleared by a sweep after reset
    logic [WAYS-1:0]  vmem [SETS];
    logic [SET_W:0]   clr_cnt_reg;
    logic             clearing;
    assign clearing       = !clr_cnt_reg[SET_W];
    assign sts.clear_done = clr_cnt_reg[SET_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (clearing)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    logic [ROW_W-1:0] row_wr;
    logic [WAYS-1:0]  vld_wr;
    logic             do_wr;

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            row_rd_reg <= mem[set_idx];
            vld_rd_reg <= vmem[set_idx];
            set_reg    <= set_idx;
        end
        if (do_wr)
            mem[set_reg] <= row_wr;
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
            vmem[clr_cnt_reg[SET_W-1:0]] <= '0;
        else if (do_wr)
            vmem[set_reg] <= vld_wr;
    end

    // ---------------- resolve ----------------
    logic [KEY_W-1:0]  w_key [WAYS];
    logic [TICK_W-1:0] w_exp [WAYS];
    logic [FSET_W-1:0] w_fac [WAYS];
    logic [WAYS-1:0]   w_hit, w_free, w_old;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            w_key[w]  = row_rd_reg[w*(KEY_W+TICK_W+FSET_W) +: KEY_W];
            w_exp[w]  = row_rd_reg[w*(KEY_W+TICK_W+FSET_W) + KEY_W +: TICK_W];
            w_fac[w]  = row_rd_reg[w*(KEY_W+TICK_W+FSET_W) + KEY_W + TICK_W +: FSET_W];
            w_hit[w]  = vld_rd_reg[w] && (w_key[w] == key_reg);
            w_free[w] = !vld_rd_reg[w];
            w_old[w]  = (now_reg >= w_exp[w]);
        end
    end

    // first set bit of each mask
    function automatic logic [WAY_W-1:0] first_one(input logic [WAYS-1:0] m);
        logic [WAY_W-1:0] r;
        r = '0;
        for (int i = WAYS - 1; i >= 0; i--)
            if (m[i])
                r = WAY_W'(i);
        return r;
    endfunction

    logic [WAY_W-1:0] hit_w, slot_w;
    logic             found, slot_ok;
    assign hit_w = first_one(w_hit);
    assign found = |w_hit;

    logic [TICK_W-1:0] h_exp;
    logic [FSET_W-1:0] h_fac;
    logic              h_live;
    assign h_exp  = w_exp[hit_w];
    assign h_fac  = w_fac[hit_w];
    assign h_live = found && (now_reg < h_exp);

    logic [VERD_W-1:0] v_n;
    logic              live_n, tout_n;
    logic [FSET_W-1:0] fac_n;
    logic [TICK_W-1:0] exp_n;
    logic [TICK_W-1:0] upd_exp;
    logic [FSET_W-1:0] upd_fac;
    logic              wr_en;
    logic [WAY_W-1:0]  wr_way;
    logic              wr_valid;

    always_comb
    begin
        v_n = V_NONE; live_n = 1'b0; tout_n = 1'b0; fac_n = '0; exp_n = '0;
        upd_exp = new_exp; upd_fac = fbit_reg;
        wr_en = 1'b0; wr_way = hit_w; wr_valid = 1'b1;
        slot_ok = 1'b1; slot_w = hit_w;
        if (op_reg == OP_INTEREST)
        begin
            if (h_live)
            begin
                upd_exp = (new_exp > h_exp) ? new_exp : h_exp;
                upd_fac = h_fac | fbit_reg;
                live_n  = 1'b1;
                if ((h_fac & fbit_reg) != '0)
                    v_n = policy_mode ? V_RETRANSMIT : V_FORWARD;
                else
                    v_n = V_AGGREGATE;
                fac_n = upd_fac; exp_n = upd_exp; wr_en = 1'b1;
            end
            else
            begin
                if (found)
                    tout_n = 1'b1;
                else if (|w_free)
                    slot_w = first_one(w_free);
                else if (|w_old)
                    slot_w = first_one(w_old);
                else
                    slot_ok = 1'b0;
                if (slot_ok)
                begin
                    v_n = V_FORWARD; fac_n = fbit_reg; exp_n = new_exp;
                    wr_en = 1'b1; wr_way = slot_w;
                end
                else
                    v_n = V_FULL;
            end
        end
        else if (found)
        begin
            exp_n  = h_exp;
            live_n = h_live;
            if (op_reg == OP_LOOKUP)
                fac_n = h_fac;
            else
            begin
                fac_n    = h_live ? h_fac : '0;
                tout_n   = !h_live;
                wr_en    = 1'b1;
                wr_valid = 1'b0;
            end
        end
    end

    always_comb
    begin
        row_wr = row_rd_reg;
        vld_wr = vld_rd_reg;
        if (wr_valid)
        begin
            row_wr[32'(wr_way)*(KEY_W+TICK_W+FSET_W) +: (KEY_W+TICK_W+FSET_W)]
                = {upd_fac, upd_exp, key_reg};
        end
        vld_wr[wr_way] = wr_valid;
    end

    assign do_wr = cmd.resolve && wr_en;

    always_ff @(posedge clk)
    begin
        if (cmd.resolve)
        begin
            verdict    <= v_n;
            found_live <= live_n;
            timed_out  <= tout_n;
            face_set   <= fac_n;
            expiry_out <= exp_n;
        end
    end

endmodule
`default_nettype wire

>>> sv/pending_interest_table_unit.sv
// pending_interest_table_unit: top level of the pending interest table.
// Depends on pit_pkg, pit_ctrl and pit_datapath.
//
// Each item passes through the unit in order: the transfer in captures it, then
// four passes of a shared 32x32 multiplier for the key hash, one set read and
// one resolve with write back to the table row. The result is registered by the
// resolve, and the next item can be taken as soon as that result is valid; a
// result still waiting in the output register holds the resolve back. After
// reset the valid bits of every set are swept clear before the first item is
// accepted. Configuration writes are taken at any time.
`default_nettype none
module pending_interest_table_unit
    import pit_pkg::*;
#(
    parameter int SETS  = 1024,
    parameter int WAYS  = 4,
    parameter int FACES = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        operation,
    input  wire logic [KEY_W-1:0]  name_key,
    input  wire logic [FACE_W-1:0] ingress_face,
    input  wire logic [LIFE_W-1:0] lifetime_ticks,
    input  wire logic [TICK_W-1:0] now_ticks,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [VERD_W-1:0]      verdict,
    output logic                   found_live,
    output logic                   timed_out,
    output logic [FSET_W-1:0]      face_set,
    output logic [TICK_W-1:0]      expiry_out,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [31:0]       cfg_data
);

    logic [LIFE_W-1:0] lifetime_reg;
    logic              policy_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= LIFE_RESET;
            policy_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LIFETIME: lifetime_reg <= cfg_data;
                CFG_POLICY:   policy_reg   <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    pit_cmd_t cmd;
    pit_sts_t sts;

    pit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    pit_datapath #(
        .SETS  (SETS),
        .WAYS  (WAYS),
        .FACES (FACES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .operation        (operation),
        .name_key         (name_key),
        .ingress_face     (ingress_face),
        .lifetime_ticks   (lifetime_ticks),
        .now_ticks        (now_ticks),
        .default_lifetime (lifetime_reg),
        .policy_mode      (policy_reg),
        .verdict          (verdict),
        .found_live       (found_live),
        .timed_out        (timed_out),
        .face_set         (face_set),
        .expiry_out       (expiry_out)
    );

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// tb_top: self-checking bench for pending_interest_table_unit.
// Depends on pit_pkg and the RTL of the unit; a shadow table predicts every verdict.
`timescale 1ns / 1ps

module tb_top;
    import pit_pkg::*;

    localparam int SETS  = 1024;
    localparam int WAYS  = 4;
    localparam int FACES = 64;
    localparam int N_RANDOM = 400;

    typedef struct {
        logic [1:0]        op;
        logic [KEY_W-1:0]  key;
        logic [FACE_W-1:0] face;
        logic [LIFE_W-1:0] life;
        logic [TICK_W-1:0] now;
    } packet_t;

    typedef struct {
        logic [VERD_W-1:0] verdict;
        logic              live;
        logic              tout;
        logic [FSET_W-1:0] faces;
        logic [TICK_W-1:0] expiry;
    } answer_t;

    // Shadow copy of the table plus the queue of answers still owed by the unit.
    class pit_shadow_table;
        logic              valid_q [SETS*WAYS];
        logic [KEY_W-1:0]  key_q   [SETS*WAYS];
        logic [TICK_W-1:0] exp_q   [SETS*WAYS];
        logic [FSET_W-1:0] faces_q [SETS*WAYS];
        logic [LIFE_W-1:0] default_life;
        logic              policy;
        answer_t           owed [$];
        int                mismatches;
        int                checked;

        function new();
            foreach (valid_q[i]) valid_q[i] = 1'b0;
            default_life = LIFE_RESET;
            policy = 1'b0;
            mismatches = 0;
            checked = 0;
        endfunction

        function int set_of(logic [KEY_W-1:0] key);
            logic [63:0] x;
            x = key;
            x = x ^ (x >> 33);
            x = x * HASH_MUL;
            x = x ^ (x >> 33);
            return int'(x % SETS);
        endfunction

        function logic [TICK_W-1:0] expiry_from(logic [TICK_W-1:0] now,
                                                logic [LIFE_W-1:0] life);
            logic [TICK_W:0] sum;
            sum = {1'b0, now} + ((life != 0) ? life : default_life);
            return sum[TICK_W] ? {TICK_W{1'b1}} : sum[TICK_W-1:0];
        endfunction

        function void note_packet(packet_t p);
            answer_t a;
            int base, hit, slot;
            logic [FSET_W-1:0] fbit;
            logic [TICK_W-1:0] e;
            logic is_live;
            base = set_of(p.key) * WAYS;
            fbit = 64'd1 << (p.face % FACES);
            a = '{V_NONE, 1'b0, 1'b0, '0, '0};
            hit = -1;
            for (int w = 0; w < WAYS; w++)
                if (hit < 0 && valid_q[base+w] && key_q[base+w] == p.key) hit = base + w;
            if (p.op == OP_INTEREST) begin
                if (hit >= 0 && p.now < exp_q[hit]) begin
                    e = expiry_from(p.now, p.life);
                    if (e > exp_q[hit]) exp_q[hit] = e;
                    a.live = 1'b1;
                    if (faces_q[hit] & fbit)
                        a.verdict = policy ? V_RETRANSMIT : V_FORWARD;
                    else begin
                        faces_q[hit] |= fbit;
                        a.verdict = V_AGGREGATE;
                    end
                    a.faces = faces_q[hit];
                    a.expiry = exp_q[hit];
                end else begin
                    slot = -1;
                    if (hit >= 0) begin
                        slot = hit;
                        a.tout = 1'b1;
                    end else begin
                        for (int w = 0; w < WAYS; w++)
                            if (slot < 0 && !valid_q[base+w]) slot = base + w;
                        for (int w = 0; w < WAYS; w++)
                            if (slot < 0 && p.now >= exp_q[base+w]) slot = base + w;
                    end
                    if (slot < 0)
                        a.verdict = V_FULL;
                    else begin
                        valid_q[slot] = 1'b1;
                        key_q[slot] = p.key;
                        exp_q[slot] = expiry_from(p.now, p.life);
                        faces_q[slot] = fbit;
                        a.verdict = V_FORWARD;
                        a.faces = fbit;
                        a.expiry = exp_q[slot];
                    end
                end
            end else if (hit >= 0) begin
                is_live = p.now < exp_q[hit];
                a.expiry = exp_q[hit];
                a.live = is_live;
                if (p.op == OP_LOOKUP)
                    a.faces = faces_q[hit];
                else begin
                    a.faces = is_live ? faces_q[hit] : '0;
                    a.tout = !is_live;
                    valid_q[hit] = 1'b0;
                end
            end
            owed.push_back(a);
        endfunction

        function void check_result(answer_t got);
            answer_t want;
            if (owed.size() == 0) begin
                $error("result with no transfer outstanding: verdict %0d", got.verdict);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            checked++;
            if (got.verdict !== want.verdict) begin
                $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                mismatches++;
            end
            if (got.live !== want.live) begin
                $error("found_live: expected %0b, got %0b", want.live, got.live);
                mismatches++;
            end
            if (got.tout !== want.tout) begin
                $error("timed_out: expected %0b, got %0b", want.tout, got.tout);
                mismatches++;
            end
            if (got.faces !== want.faces) begin
                $error("face_set: expected %h, got %h", want.faces, got.faces);
                mismatches++;
            end
            if (got.expiry !== want.expiry) begin
                $error("expiry_out: expected %h, got %h", want.expiry, got.expiry);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] operation;
    logic [KEY_W-1:0] name_key;
    logic [FACE_W-1:0] ingress_face;
    logic [LIFE_W-1:0] lifetime_ticks;
    logic [TICK_W-1:0] now_ticks;
    logic out_valid;
    logic out_stall;
    logic [VERD_W-1:0] verdict;
    logic found_live;
    logic timed_out;
    logic [FSET_W-1:0] face_set;
    logic [TICK_W-1:0] expiry_out;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [31:0] cfg_data;

    pit_shadow_table shadow;
    logic [KEY_W-1:0] crowd_keys [8];  // all hash to one set
    logic [KEY_W-1:0] pool_keys [24];
    logic [TICK_W-1:0] clock_ticks;
    int sent;
    bit calm;

    pending_interest_table_unit #(.SETS(SETS), .WAYS(WAYS), .FACES(FACES)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .name_key(name_key), .ingress_face(ingress_face),
        .lifetime_ticks(lifetime_ticks), .now_ticks(now_ticks),
        .out_valid(out_valid), .out_stall(out_stall),
        .verdict(verdict), .found_live(found_live), .timed_out(timed_out),
        .face_set(face_set), .expiry_out(expiry_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            shadow.check_result('{verdict, found_live, timed_out, face_set, expiry_out});
    end

    // Receiver back-pressure: runs of free cycles, short stalls, now and then a long one.
    int stall_run = 0;
    always @(negedge clk)
    begin
        int r;
        if (stall_run > 0)
            stall_run--;
        else begin
            r = $urandom_range(0, 99);
            if (calm || r < 65) begin
                out_stall <= 1'b0;
                stall_run = $urandom_range(1, 20);
            end else if (r < 94) begin
                out_stall <= 1'b1;
                stall_run = $urandom_range(0, 3);
            end else begin
                out_stall <= 1'b1;
                stall_run = $urandom_range(10, 40);
            end
        end
    end

    task automatic write_reg(logic idx, logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_LIFETIME)
            shadow.default_life = value;
        else
            shadow.policy = value[0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send(packet_t p);
        int r;
        in_valid = 1'b1;
        operation = p.op;
        name_key = p.key;
        ingress_face = p.face;
        lifetime_ticks = p.life;
        now_ticks = p.now;
        do @(posedge clk); while (in_stall);
        shadow.note_packet(p);
        sent++;
        @(negedge clk);
        r = $urandom_range(0, 99);
        if (!calm && r >= 55) begin
            in_valid = 1'b0;
            if (r < 92)
                repeat ($urandom_range(1, 3)) @(negedge clk);
            else
                repeat ($urandom_range(10, 40)) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (shadow.owed.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic send_one(logic [1:0] op, logic [KEY_W-1:0] key, logic [FACE_W-1:0] face,
                            logic [LIFE_W-1:0] life, logic [TICK_W-1:0] now);
        send('{op, key, face, life, now});
    endtask

    task automatic random_phase(int count);
        packet_t p;
        int r;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 49) == 0) calm = !calm;
            r = $urandom_range(0, 99);
            p.op = (r < 50) ? OP_INTEREST : (r < 70) ? OP_DATA : (r < 80) ? OP_REMOVE
                                                                       : OP_LOOKUP;
            r = $urandom_range(0, 99);
            if (r < 40)
                p.key = crowd_keys[$urandom_range(0, 7)];
            else if (r < 90)
                p.key = pool_keys[$urandom_range(0, 23)];
            else
                p.key = {$urandom, $urandom};
            p.face = ($urandom_range(0, 3) == 0) ? FACE_W'($urandom_range(0, 63))
                                                 : FACE_W'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            p.life = (r < 10) ? '0 : (r < 15) ? $urandom : $urandom_range(1, 300);
            clock_ticks += $urandom_range(0, 40);
            if ($urandom_range(0, 32) == 0)
                p.now = TICK_W'({$urandom, $urandom});
            else
                p.now = clock_ticks;
            send(p);
        end
    endtask

    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int target;
        int found;
        logic [KEY_W-1:0] k;
        shadow = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_INTEREST;
        name_key = '0;
        ingress_face = '0;
        lifetime_ticks = '0;
        now_ticks = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LIFETIME;
        cfg_data = '0;
        sent = 0;
        calm = 1'b0;
        clock_ticks = 48'd5000;
        foreach (pool_keys[i]) pool_keys[i] = {$urandom, $urandom};
        target = shadow.set_of(pool_keys[0]);
        crowd_keys[0] = pool_keys[0];
        found = 1;
        while (found < 8) begin
            k = {$urandom, $urandom};
            if (shadow.set_of(k) == target) begin
                crowd_keys[found] = k;
                found++;
            end
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(CFG_LIFETIME, 32'd4000);
        write_reg(CFG_POLICY, 32'd0);
        // directed: aggregation, satisfy, remove, lookup, expiry, full set, saturation
        send_one(OP_INTEREST, 64'h0, 6'd0, 32'd100, 48'd1000);
        send_one(OP_INTEREST, 64'h0, 6'd0, 32'd500, 48'd1010);
        send_one(OP_INTEREST, 64'h0, 6'd63, 32'd1, 48'd1020);
        send_one(OP_LOOKUP, 64'h0, 6'd5, 32'd0, 48'd1030);
        send_one(OP_DATA, 64'h0, 6'd5, 32'd0, 48'd1040);
        send_one(OP_DATA, 64'h0, 6'd5, 32'd0, 48'd1050);
        send_one(OP_REMOVE, {KEY_W{1'b1}}, 6'd1, 32'd0, 48'd1060);
        send_one(OP_INTEREST, {KEY_W{1'b1}}, 6'd42, 32'd0, 48'd1070);
        send_one(OP_REMOVE, {KEY_W{1'b1}}, 6'd1, 32'd0, 48'd1080);
        send_one(OP_INTEREST, 64'h55, 6'd21, 32'd10, 48'd2000);
        send_one(OP_LOOKUP, 64'h55, 6'd21, 32'd0, 48'd2010);
        send_one(OP_INTEREST, 64'h55, 6'd22, 32'd10, 48'd2020);
        send_one(OP_DATA, 64'h55, 6'd0, 32'd0, 48'd3000);
        for (int i = 0; i < 5; i++)
            send_one(OP_INTEREST, crowd_keys[i], 6'(i), 32'd50, 48'd3000);
        send_one(OP_INTEREST, crowd_keys[5], 6'd9, 32'd50, 48'd3100);
        send_one(OP_REMOVE, crowd_keys[1], 6'd0, 32'd0, 48'd3200);
        send_one(OP_INTEREST, 64'hA5A5, 6'd7, 32'hFFFF_FFFF, {TICK_W{1'b1}} - 1);
        send_one(OP_INTEREST, 64'hA5A5, 6'd8, 32'hFFFF_FFFF, {TICK_W{1'b1}} - 1);
        send_one(OP_LOOKUP, 64'hA5A5, 6'd0, 32'd0, {TICK_W{1'b1}});
        drain();

        write_reg(CFG_POLICY, 32'd1);
        write_reg(CFG_LIFETIME, 32'd0);
        random_phase(N_RANDOM / 4);
        drain();
        write_reg(CFG_LIFETIME, 32'hFFFF_FFFF);
        write_reg(CFG_POLICY, 32'd0);
        random_phase(N_RANDOM / 4);
        drain();
        write_reg(CFG_LIFETIME, 32'd50);
        write_reg(CFG_POLICY, 32'd1);
        random_phase(N_RANDOM / 2);
        drain();

        $display("Run covered %0d transfers over four register settings; %0d results checked.",
                 sent, shadow.checked);
        if (shadow.mismatches == 0 && shadow.owed.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

>>> filelist.f
sv/pit_pkg.sv
sv/pit_ctrl.sv
sv/pit_datapath.sv
sv/pending_interest_table_unit.sv
bench/tb_top.sv
